### rtl/dda_pkg.sv
package dda_pkg;

  localparam logic signed [15:0] SCREEN_WIDTH  = 16'sd1920;
  localparam logic signed [15:0] SCREEN_HEIGHT = 16'sd1080;

  // restoring divider: one quotient bit per cycle over a 33-bit dividend
  localparam int DIV_STEPS = 33;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic {
    KIND_LOAD    = 1'b0,
    KIND_ADVANCE = 1'b1
  } kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_DIVIDE
  } state_e;

  typedef struct packed {
    logic signed [15:0] x_start;
    logic signed [15:0] y_start;
    logic signed [31:0] z_start;
    logic signed [15:0] x_end;
    logic signed [15:0] y_end;
    logic signed [31:0] z_end;
  } line_t;

  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic signed [31:0] pixel_z;
    logic [15:0]        mix_weight;
    logic               last;
  } pixel_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic off_screen;
    logic last_step;
  } dp_sts_t;

endpackage

### rtl/dda_in_if.sv
interface dda_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] x_start;
  logic signed [15:0] y_start;
  logic signed [31:0] z_start;
  logic signed [15:0] x_end;
  logic signed [15:0] y_end;
  logic signed [31:0] z_end;

  modport source (
    output valid, kind, x_start, y_start, z_start, x_end, y_end, z_end,
    input  ready
  );

  modport sink (
    input  valid, kind, x_start, y_start, z_start, x_end, y_end, z_end,
    output ready
  );
endinterface

### rtl/dda_out_if.sv
interface dda_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pixel_x;
  logic signed [15:0] pixel_y;
  logic signed [31:0] pixel_z;
  logic [15:0]        mix_weight;
  logic               last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_z, mix_weight, last,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, pixel_z, mix_weight, last,
    output ready
  );
endinterface

### rtl/dda_dp.sv
module dda_dp (
  input  logic             clk_i,
  input  dda_pkg::line_t   line_i,
  input  dda_pkg::dp_cmd_t cmd_i,
  output dda_pkg::dp_sts_t sts_o,
  output dda_pkg::pixel_t  pixel_o
);

  // remainder accumulator step: returns {carry, new remainder}
  function automatic logic [16:0] acc_step(logic [15:0] rem, logic [15:0] inc,
                                           logic [15:0] len);
    logic [16:0] sum;
    logic [16:0] dif;
    sum = {1'b0, rem} + {1'b0, inc};
    dif = sum - {1'b0, len};
    if (sum >= {1'b0, len}) begin
      return {1'b1, dif[15:0]};
    end
    return {1'b0, sum[15:0]};
  endfunction

  logic [16:0] dx, dy, ax, ay;
  logic [32:0] dz, az;
  logic [15:0] len_new;
  logic        off_x, off_y;

  logic [15:0] origin_x_q, origin_y_q;
  logic [31:0] origin_z_q;
  logic        neg_x_q, neg_y_q, neg_z_q;
  logic [15:0] mag_x_q, mag_y_q, len_q, step_q;
  logic [15:0] qx_q, rx_q, qy_q, ry_q;
  logic [31:0] qz_q;
  logic [15:0] rz_q, qw_q, rw_q;
  logic [32:0] divz_q, divw_q;
  logic [15:0] remz_q, remw_q;
  dda_pkg::pixel_t pix_q, pix_d;

  logic [16:0] tz, tw, tz_dif, tw_dif;
  logic        gez, gew;
  logic [16:0] nx, ny, nz, nw;

  // line setup from the endpoints
  always_comb begin
    dx = {line_i.x_end[15], line_i.x_end} - {line_i.x_start[15], line_i.x_start};
    dy = {line_i.y_end[15], line_i.y_end} - {line_i.y_start[15], line_i.y_start};
    dz = {line_i.z_end[31], line_i.z_end} - {line_i.z_start[31], line_i.z_start};
    ax = dx[16] ? (17'd0 - dx) : dx;
    ay = dy[16] ? (17'd0 - dy) : dy;
    az = dz[32] ? (33'd0 - dz) : dz;
    len_new = (ax >= ay) ? ax[15:0] : ay[15:0];
    if (len_new == 16'd0) begin
      len_new = 16'd1;
    end
    off_x = (line_i.x_start[15] && line_i.x_end[15]) ||
            (line_i.x_start >= dda_pkg::SCREEN_WIDTH &&
             line_i.x_end >= dda_pkg::SCREEN_WIDTH);
    off_y = (line_i.y_start[15] && line_i.y_end[15]) ||
            (line_i.y_start >= dda_pkg::SCREEN_HEIGHT &&
             line_i.y_end >= dda_pkg::SCREEN_HEIGHT);
  end

  // one step of both step-size divisions: |dz| / len and 65536 / len
  always_comb begin
    tz     = {remz_q, divz_q[32]};
    tw     = {remw_q, divw_q[32]};
    tz_dif = tz - {1'b0, len_q};
    tw_dif = tw - {1'b0, len_q};
    gez    = tz >= {1'b0, len_q};
    gew    = tw >= {1'b0, len_q};
  end

  // pixel of the current step and the accumulator advance
  always_comb begin
    nx = acc_step(rx_q, mag_x_q, len_q);
    ny = acc_step(ry_q, mag_y_q, len_q);
    nz = acc_step(rz_q, remz_q, len_q);
    nw = acc_step(rw_q, remw_q, len_q);
    pix_d.pixel_x    = neg_x_q ? (origin_x_q - qx_q) : (origin_x_q + qx_q);
    pix_d.pixel_y    = neg_y_q ? (origin_y_q - qy_q) : (origin_y_q + qy_q);
    // rounds up: a positive slope with a remainder takes the next integer
    pix_d.pixel_z    = neg_z_q ? (origin_z_q - qz_q)
                               : (origin_z_q + qz_q + 32'(rz_q != 16'd0));
    pix_d.mix_weight = qw_q;
    pix_d.last       = ({1'b0, step_q} + 17'd1) == {1'b0, len_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      origin_x_q <= line_i.x_start;
      origin_y_q <= line_i.y_start;
      origin_z_q <= line_i.z_start;
      neg_x_q    <= dx[16];
      neg_y_q    <= dy[16];
      neg_z_q    <= dz[32];
      mag_x_q    <= ax[15:0];
      mag_y_q    <= ay[15:0];
      len_q      <= len_new;
      step_q     <= '0;
      qx_q       <= '0;
      rx_q       <= '0;
      qy_q       <= '0;
      ry_q       <= '0;
      qz_q       <= '0;
      rz_q       <= '0;
      qw_q       <= '0;
      rw_q       <= '0;
      divz_q     <= az;
      remz_q     <= '0;
      divw_q     <= 33'h0_0001_0000;
      remw_q     <= '0;
    end else if (cmd_i.div_step) begin
      divz_q <= {divz_q[31:0], gez};
      remz_q <= gez ? tz_dif[15:0] : tz[15:0];
      divw_q <= {divw_q[31:0], gew};
      remw_q <= gew ? tw_dif[15:0] : tw[15:0];
    end else if (cmd_i.emit) begin
      pix_q  <= pix_d;
      step_q <= step_q + 16'd1;
      qx_q   <= qx_q + 16'(nx[16]);
      rx_q   <= nx[15:0];
      qy_q   <= qy_q + 16'(ny[16]);
      ry_q   <= ny[15:0];
      qz_q   <= qz_q + divz_q[31:0] + 32'(nz[16]);
      rz_q   <= nz[15:0];
      qw_q   <= qw_q + divw_q[15:0] + 16'(nw[16]);
      rw_q   <= nw[15:0];
    end
  end

  assign sts_o.off_screen = off_x || off_y;
  assign sts_o.last_step  = pix_d.last;
  assign pixel_o          = pix_q;

endmodule

### rtl/dda_ctrl.sv
module dda_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_kind_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  dda_pkg::dp_sts_t sts_i,
  output dda_pkg::dp_cmd_t cmd_o
);

  dda_pkg::state_e               state_q, state_d;
  logic [dda_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                          active_q, active_d;
  logic                          out_valid_q, out_valid_d;
  logic                          in_ready;
  dda_pkg::dp_cmd_t              cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dda_pkg::ST_IDLE;
      cnt_q       <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    active_d    = active_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready    = 1'b0;
    cmd         = '0;
    case (state_q)
      dda_pkg::ST_IDLE: begin
        // output slot free or draining this cycle
        in_ready = !out_valid_q || out_ready_i;
        if (in_valid_i && in_ready) begin
          if (in_kind_i == dda_pkg::KIND_LOAD) begin
            cmd.load = 1'b1;
            if (sts_i.off_screen) begin
              active_d = 1'b0;
            end else begin
              active_d = 1'b1;
              state_d  = dda_pkg::ST_DIVIDE;
              cnt_d    = dda_pkg::DIV_CNT_W'(dda_pkg::DIV_STEPS - 1);
            end
          end else if (active_q) begin
            cmd.emit    = 1'b1;
            out_valid_d = 1'b1;
            if (sts_i.last_step) begin
              active_d = 1'b0;
            end
          end
        end
      end
      dda_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        cnt_d        = cnt_q - dda_pkg::DIV_CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = dda_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dda_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  a_emit_needs_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> active_q && state_q == dda_pkg::ST_IDLE)
    else $error("pixel emitted without an active line");

  a_no_accept_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dda_pkg::ST_DIVIDE |-> !in_ready_o && !cmd.emit && !cmd.load)
    else $error("item taken while step sizes are being divided");

  a_emit_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> out_valid_o)
    else $error("emitted pixel not presented");

  a_load_starts_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load && !sts_i.off_screen |=> state_q == dda_pkg::ST_DIVIDE && active_q)
    else $error("on-screen line did not start setup");

  a_off_screen_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load && sts_i.off_screen |=> !active_q && state_q == dda_pkg::ST_IDLE)
    else $error("off-screen line left active");

endmodule

### rtl/dda_line_rasterizer.sv
// advance item: pixel is presented in the cycle after acceptance, one pixel per cycle
// sustained while the output side keeps taking them (single output register)
// load item: accepted, then the step sizes are divided (one quotient bit per
// cycle in two parallel restoring dividers); an off-screen load skips the division
// reset (rst_ni, async, active low) clears the controller: no line, no pixel pending
module dda_line_rasterizer (
  input logic      clk_i,
  input logic      rst_ni,
  dda_in_if.sink   line_i,
  dda_out_if.source pixel_o
);

  dda_pkg::line_t   line;
  dda_pkg::pixel_t  pix;
  dda_pkg::dp_cmd_t cmd;
  dda_pkg::dp_sts_t sts;

  assign line.x_start = line_i.x_start;
  assign line.y_start = line_i.y_start;
  assign line.z_start = line_i.z_start;
  assign line.x_end   = line_i.x_end;
  assign line.y_end   = line_i.y_end;
  assign line.z_end   = line_i.z_end;

  dda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (line_i.valid),
    .in_kind_i   (line_i.kind),
    .in_ready_o  (line_i.ready),
    .out_valid_o (pixel_o.valid),
    .out_ready_i (pixel_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dda_dp u_dp (
    .clk_i   (clk_i),
    .line_i  (line),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .pixel_o (pix)
  );

  assign pixel_o.pixel_x    = pix.pixel_x;
  assign pixel_o.pixel_y    = pix.pixel_y;
  assign pixel_o.pixel_z    = pix.pixel_z;
  assign pixel_o.mix_weight = pix.mix_weight;
  assign pixel_o.last       = pix.last;

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;

  typedef struct packed {
    logic           hold;
    dda_pkg::kind_e kind;
    dda_pkg::line_t line;
  } line_req_t;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 64;

  logic clk;
  logic rst_n;

  dda_in_if  line_if ();
  dda_out_if pixel_if ();

  dda_line_rasterizer dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .line_i  (line_if),
    .pixel_o (pixel_if)
  );

  line_req_t       line_queue[$];
  dda_pkg::pixel_t pixel_expect[$];
  line_req_t       sent_item;
  logic      in_busy = 1'b0;
  int        errors = 0;
  int        idle_cycles = 0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        stall_mode = 0;
  int        mode_left = 0;

  // rasterizer state as the predictor sees it
  bit     line_on = 1'b0;
  longint step_i = 0;
  longint span_len = 0;
  longint org_x = 0;
  longint org_y = 0;
  longint org_z = 0;
  longint dx_s = 0;
  longint dy_s = 0;
  longint dz_s = 0;

  function automatic bit off_pair(input longint a, input longint b, input longint lim);
    return (a < 0 && b < 0) || (a >= lim && b >= lim);
  endfunction

  // returns 1 when the item produces a pixel
  function automatic bit rasterize_item(input line_req_t req, output dda_pkg::pixel_t pix);
    longint x1, y1, z1, x2, y2, z2, ax, ay, n, q, w;
    pix = '0;
    if (req.kind == dda_pkg::KIND_LOAD) begin
      x1 = $signed(req.line.x_start);
      y1 = $signed(req.line.y_start);
      z1 = $signed(req.line.z_start);
      x2 = $signed(req.line.x_end);
      y2 = $signed(req.line.y_end);
      z2 = $signed(req.line.z_end);
      if (off_pair(x1, x2, dda_pkg::SCREEN_WIDTH) ||
          off_pair(y1, y2, dda_pkg::SCREEN_HEIGHT)) begin
        line_on = 1'b0;
        step_i = 0;
        return 1'b0;
      end
      org_x = x1;
      org_y = y1;
      org_z = z1;
      dx_s = x2 - x1;
      dy_s = y2 - y1;
      dz_s = z2 - z1;
      ax = (dx_s < 0) ? -dx_s : dx_s;
      ay = (dy_s < 0) ? -dy_s : dy_s;
      span_len = (ay > ax) ? ay : ax;
      if (span_len == 0) span_len = 1;
      step_i = 0;
      line_on = 1'b1;
      return 1'b0;
    end
    if (!line_on) return 1'b0;
    // depth rounds toward +inf, x and y truncate toward zero
    n = step_i * dz_s;
    q = n / span_len;
    if (n % span_len != 0 && n > 0) q = q + 1;
    w = (step_i << 16) / span_len;
    pix.pixel_x = 16'(org_x + (step_i * dx_s) / span_len);
    pix.pixel_y = 16'(org_y + (step_i * dy_s) / span_len);
    pix.pixel_z = 32'(org_z + q);
    pix.mix_weight = 16'(w);
    step_i = step_i + 1;
    pix.last = (step_i >= span_len);
    if (pix.last) line_on = 1'b0;
    return 1'b1;
  endfunction

  task automatic queue_load(input int x1, input int y1, input int z1,
                            input int x2, input int y2, input int z2, input bit hold);
    line_req_t req;
    req.hold = hold;
    req.kind = dda_pkg::KIND_LOAD;
    req.line.x_start = 16'(x1);
    req.line.y_start = 16'(y1);
    req.line.z_start = 32'(z1);
    req.line.x_end = 16'(x2);
    req.line.y_end = 16'(y2);
    req.line.z_end = 32'(z2);
    line_queue.push_back(req);
  endtask

  task automatic queue_advance(input int count);
    line_req_t req;
    for (int k = 0; k < count; k++) begin
      req.hold = 1'b0;
      req.kind = dda_pkg::KIND_ADVANCE;
      // payload is ignored on advance, keep it noisy
      req.line = {$urandom(), $urandom(), $urandom(), $urandom()};
      line_queue.push_back(req);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : stimulus
    int x1, y1, x2, y2, z1, dx, dy, len, adv, r, budget;

    // directed part
    queue_advance(1);                                  // no line loaded yet
    queue_load(0, 0, 0, 4, 3, -7, 1'b0);               // negative depth slope
    queue_advance(5);                                  // last one falls past the end
    queue_load(100, 100, 5, 100, 100, 9, 1'b0);        // single pixel line
    queue_advance(2);
    queue_load(-5, 10, 0, -1, 20, 0, 1'b0);            // left of screen
    queue_load(1920, 10, 0, 32767, 20, 0, 1'b0);       // right of screen
    queue_load(10, -32768, 0, 20, -1, 0, 1'b0);        // above screen
    queue_load(10, 1080, 0, 20, 1080, 0, 1'b0);        // below screen
    queue_advance(1);
    queue_load(-32768, -32768, 32'h8000_0000, 32767, 32767, 32'h7fff_ffff, 1'b0);
    queue_advance(2);
    // replaces the line still in progress
    queue_load(32767, -32768, 32'h7fff_ffff, -32768, 32767, 32'h8000_0000, 1'b0);
    queue_advance(2);
    queue_load(10, 0, 100, 12, -5, 3, 1'b1);           // steep, sent once drained
    queue_advance(6);

    // widest span, replaced after a few pixels
    queue_load(-32768, 0, $urandom(), 32767, 1079, $urandom(), 1'b0);
    queue_advance(8);

    budget = 0;
    while (budget < 1000) begin
      r = $urandom_range(0, 99);
      z1 = $urandom();
      x1 = int'($urandom_range(0, 2000)) - 40;
      y1 = int'($urandom_range(0, 1160)) - 40;
      adv = 0;
      if (r < 55 || r >= 92) begin
        if (r < 55) begin
          dx = int'($urandom_range(0, 48)) - 24;
          dy = int'($urandom_range(0, 48)) - 24;
        end else begin
          dx = int'($urandom_range(0, 800)) - 400;
          dy = int'($urandom_range(0, 800)) - 400;
        end
        len = (dx < 0) ? -dx : dx;
        if (((dy < 0) ? -dy : dy) > len) len = (dy < 0) ? -dy : dy;
        if (len == 0) len = 1;
        queue_load(x1, y1, z1, x1 + dx, y1 + dy,
                   $urandom_range(0, 1) ? $urandom() : z1 + int'($urandom_range(0, 200)) - 100,
                   $urandom_range(0, 49) == 0);
        if (r < 55 && $urandom_range(0, 4) == 0) adv = $urandom_range(0, len);
        else adv = len + int'($urandom_range(0, 2));
        budget += 1 + adv;
      end else if (r < 65) begin
        queue_load(x1, y1, z1, x1, y1, $urandom(), 1'b0);
        adv = $urandom_range(1, 3);
        budget += 2;
      end else if (r < 75) begin
        x2 = int'($urandom_range(0, 65535)) - 32768;
        y2 = int'($urandom_range(0, 65535)) - 32768;
        case ($urandom_range(0, 3))
          0: queue_load(-int'($urandom_range(1, 32768)), y1, z1,
                        -int'($urandom_range(1, 32768)), y2, $urandom(), 1'b0);
          1: queue_load($urandom_range(1920, 32767), y1, z1,
                        $urandom_range(1920, 32767), y2, $urandom(), 1'b0);
          2: queue_load(x1, -int'($urandom_range(1, 32768)), z1,
                        x2, -int'($urandom_range(1, 32768)), $urandom(), 1'b0);
          default: queue_load(x1, $urandom_range(1080, 32767), z1,
                              x2, $urandom_range(1080, 32767), $urandom(), 1'b0);
        endcase
        adv = $urandom_range(0, 2);
        budget += 1;
      end else begin
        queue_load($urandom(), $urandom(), z1, $urandom(), $urandom(), $urandom(), 1'b0);
        adv = $urandom_range(0, 8);
        budget += 1 + adv;
      end
      queue_advance(adv);
    end
  end

  initial begin : run_ctl
    rst_n = 1'b0;
    line_if.valid = 1'b0;
    line_if.kind = dda_pkg::KIND_LOAD;
    line_if.x_start = '0;
    line_if.y_start = '0;
    line_if.z_start = '0;
    line_if.x_end = '0;
    line_if.y_end = '0;
    line_if.z_end = '0;
    pixel_if.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    while (line_queue.size() != 0 || in_busy) @(posedge clk);
    while (pixel_expect.size() != 0) @(posedge clk);
    // a trailing load may still be dividing
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // sender: bursts of items with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      line_if.valid <= 1'b0;
    end else if (!in_busy) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        line_if.valid <= 1'b0;
      end else if (line_queue.size() != 0 &&
                   !(line_queue[0].hold && pixel_expect.size() != 0)) begin
        sent_item = line_queue.pop_front();
        line_if.valid <= 1'b1;
        line_if.kind <= sent_item.kind;
        line_if.x_start <= sent_item.line.x_start;
        line_if.y_start <= sent_item.line.y_start;
        line_if.z_start <= sent_item.line.z_start;
        line_if.x_end <= sent_item.line.x_end;
        line_if.y_end <= sent_item.line.y_end;
        line_if.z_end <= sent_item.line.z_end;
        in_busy <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end else begin
          burst_left = burst_left - 1;
        end
      end else begin
        line_if.valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches between always ready, random and mostly stalled
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 300);
    end else begin
      mode_left = mode_left - 1;
    end
    case (stall_mode)
      0: pixel_if.ready <= 1'b1;
      1: pixel_if.ready <= $urandom_range(0, 1);
      default: pixel_if.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin : check_port
    dda_pkg::pixel_t got, want, pix;
    bit moved;
    if (rst_n) begin
      moved = 1'b0;
      if (pixel_if.valid && pixel_if.ready) begin
        moved = 1'b1;
        got = {pixel_if.pixel_x, pixel_if.pixel_y, pixel_if.pixel_z,
               pixel_if.mix_weight, pixel_if.last};
        if (pixel_expect.size() == 0) begin
          $display("%0t: pixel mismatch, expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = pixel_expect.pop_front();
          compare_field("pixel_x", want.pixel_x, got.pixel_x);
          compare_field("pixel_y", want.pixel_y, got.pixel_y);
          compare_field("pixel_z", want.pixel_z, got.pixel_z);
          compare_field("mix_weight", want.mix_weight, got.mix_weight);
          compare_field("last", want.last, got.last);
        end
      end
      if (line_if.valid && line_if.ready) begin
        moved = 1'b1;
        if (rasterize_item(sent_item, pix)) pixel_expect.push_back(pix);
        in_busy <= 1'b0;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule

### filelist.f
rtl/dda_pkg.sv
rtl/dda_in_if.sv
rtl/dda_out_if.sv
rtl/dda_dp.sv
rtl/dda_ctrl.sv
rtl/dda_line_rasterizer.sv
test/tb.sv
